[src/fpst_pkg.sv]
// Shared widths and types for the binary indexed prefix-sum table.
package fpst_pkg;

  // Field widths fixed by the interface
  localparam int IdxW = 11;
  localparam int ValW = 32;
  localparam int SumW = 64;

  typedef logic        [IdxW-1:0] idx_t;
  typedef logic signed [ValW-1:0] val_t;
  typedef logic signed [SumW-1:0] sum_t;

  // Operation codes on op_i
  localparam logic OpAdd   = 1'b0;
  localparam logic OpQuery = 1'b1;

endpackage

[src/fpst_node_ram.sv]
// Node store: one write port and one read port, read data registered.
module fpst_node_ram #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  fpst_pkg::sum_t      wr_data_i,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output fpst_pkg::sum_t      rd_data_o
);
  import fpst_pkg::*;

  sum_t mem_q [Depth];
  sum_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, read data registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/fenwick_prefix_sum_table_unit.sv]
// Binary indexed prefix-sum table: top level with walk sequencer and node store.
// After reset a clearing pass writes zero to every node, with no request taken.
// An add visits k <= log2(SIZE)+1 nodes, one read-modify-write per cycle.
// A query visits at most k nodes likewise; its result is registered in S_HOLD once the output is free.
// Out-of-range adds are dropped and count-zero queries return zero. The single memory port pair
// (one read, one write per cycle) serves each walk; a new request waits until the last is done.
module fenwick_prefix_sum_table_unit #(
  parameter int SIZE = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  fpst_pkg::idx_t   index_i,
  input  fpst_pkg::val_t   value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fpst_pkg::sum_t   prefix_sum_o
);
  import fpst_pkg::*;

  localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int CW = $clog2(SIZE + 1) + 1;
  localparam int NW = (CW > IdxW + 1) ? CW : IdxW + 1;
  localparam logic [NW-1:0] SizeN = NW'(SIZE);
  localparam logic [AW-1:0] LastAddr = AW'(SIZE - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_QRY,
    S_HOLD
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   clr_q;
  logic [NW-1:0]   node_q;
  sum_t            amount_q;
  sum_t            acc_q;
  logic            out_valid_q;
  sum_t            out_q;

  logic            in_acc;
  logic            out_free;
  logic [NW-1:0]   idx_ext;
  logic [NW-1:0]   cnt;
  logic [NW-1:0]   cnt_m1;
  logic            add_ok;
  logic [NW-1:0]   low_bit;
  logic [NW-1:0]   next_up;
  logic [NW-1:0]   next_dn;
  logic [NW-1:0]   node_m1;
  logic [NW-1:0]   up_m1;
  logic [NW-1:0]   dn_m1;
  logic            up_more;
  logic            dn_more;
  sum_t            sum_wr;
  sum_t            sum_acc;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  sum_t            wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  sum_t            rd_data;

  // Handshake
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign prefix_sum_o = out_q;

  // Request decode: query count saturates at SIZE, adds past the end are dropped
  assign idx_ext = NW'(index_i);
  assign cnt     = (idx_ext > SizeN) ? SizeN : idx_ext;
  assign cnt_m1  = cnt - NW'(1);
  assign add_ok  = (idx_ext < SizeN);

  // Tree stepping: up by lowest set bit for adds, down for queries
  assign low_bit = node_q & (~node_q + NW'(1));
  assign next_up = node_q + low_bit;
  assign next_dn = node_q & (node_q - NW'(1));
  assign node_m1 = node_q - NW'(1);
  assign up_m1   = next_up - NW'(1);
  assign dn_m1   = next_dn - NW'(1);
  assign up_more = (next_up <= SizeN);
  assign dn_more = (next_dn != '0);
  assign sum_wr  = rd_data + amount_q;
  assign sum_acc = acc_q + rd_data;

  // Memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = idx_ext[AW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OpAdd) begin
            rd_en   = add_ok;
            rd_addr = idx_ext[AW-1:0];
          end else begin
            rd_en   = (cnt != '0);
            rd_addr = cnt_m1[AW-1:0];
          end
        end
      end
      S_ADD: begin
        wr_en   = 1'b1;
        wr_addr = node_m1[AW-1:0];
        wr_data = sum_wr;
        rd_en   = up_more;
        rd_addr = up_m1[AW-1:0];
      end
      S_QRY: begin
        rd_en   = dn_more;
        rd_addr = dn_m1[AW-1:0];
      end
      S_HOLD: begin
        rd_en = 1'b0;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      node_q      <= '0;
      amount_q    <= '0;
      acc_q       <= '0;
      out_q       <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == LastAddr) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            amount_q <= {{(SumW-ValW){value_i[ValW-1]}}, value_i};
            acc_q    <= '0;
            if (op_i == OpAdd) begin
              node_q <= idx_ext + NW'(1);
              if (add_ok) begin
                state_q <= S_ADD;
              end
            end else begin
              node_q <= cnt;
              state_q <= (cnt != '0) ? S_QRY : S_HOLD;
            end
          end
        end
        S_ADD: begin
          node_q <= next_up;
          if (!up_more) begin
            state_q <= S_IDLE;
          end
        end
        S_QRY: begin
          acc_q  <= sum_acc;
          node_q <= next_dn;
          if (!dn_more) begin
            state_q <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_q       <= acc_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Result valid flag: set when the held sum moves out, cleared once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_HOLD && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  fpst_node_ram #(
    .Depth (SIZE),
    .AddrW (AW)
  ) u_node_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule
